FILE: rtl/core/ccm_pkg.sv
`default_nettype none

package ccm_pkg;

    // sample and coefficient formats
    localparam int SAMPLE_WIDTH = 10;
    localparam int COEFF_WIDTH  = 16;
    localparam int COEFF_FRAC   = 12;
    localparam int NARROW_WIDTH = 8;
    localparam int ROW_WIDTH    = 3 * COEFF_WIDTH;

    // unsigned sample widened by a sign bit, times a signed coefficient
    localparam int PROD_WIDTH   = SAMPLE_WIDTH + 1 + COEFF_WIDTH;
    // three products summed
    localparam int SUM_WIDTH    = PROD_WIDTH + 2;

    localparam int CFG_INDEX_WIDTH = 2;

    localparam logic [SAMPLE_WIDTH-1:0] MAX_8BIT  = SAMPLE_WIDTH'(8'hFF);
    localparam logic [SAMPLE_WIDTH-1:0] MAX_10BIT = SAMPLE_WIDTH'(10'h3FF);
    localparam logic [SAMPLE_WIDTH-1:0] MIN_OUT   = SAMPLE_WIDTH'(8'h00);

    localparam logic [COEFF_WIDTH-1:0] COEFF_ONE = COEFF_WIDTH'(1) << COEFF_FRAC;

    localparam logic [ROW_WIDTH-1:0] ROW_RED_RESET   =
        {COEFF_ONE, {COEFF_WIDTH{1'b0}}, {COEFF_WIDTH{1'b0}}};
    localparam logic [ROW_WIDTH-1:0] ROW_GREEN_RESET =
        {{COEFF_WIDTH{1'b0}}, COEFF_ONE, {COEFF_WIDTH{1'b0}}};
    localparam logic [ROW_WIDTH-1:0] ROW_BLUE_RESET  =
        {{COEFF_WIDTH{1'b0}}, {COEFF_WIDTH{1'b0}}, COEFF_ONE};

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_ROW_RED   = 2'd0,
        CFG_ROW_GREEN = 2'd1,
        CFG_ROW_BLUE  = 2'd2,
        CFG_TEN_BIT   = 2'd3
    } cfg_index_t;

    // per-stage load enables of the row datapath
    typedef struct packed {
        logic mul;
        logic sum;
        logic clamp;
    } adv_t;

endpackage

`default_nettype wire

FILE: rtl/core/color_correction_matrix.sv
// colour correction matrix, 3x3 signed q4.12 coefficients applied to one rgb pixel
// a request passes the sample, product, sum and clamp registers to res_valid
// throughput: one pixel per cycle; a stalled output holds, and upstream bubbles
// are squeezed out so requests keep being taken while empty stages remain
// reset: pipeline valids cleared, identity matrix loaded, 8-bit mode selected
`default_nettype none

module color_correction_matrix
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,

    // pixel request channel
    input  wire logic                                 pix_valid,
    output logic                                      pix_stall,
    input  wire logic [ccm_pkg::SAMPLE_WIDTH-1:0]     red_in,
    input  wire logic [ccm_pkg::SAMPLE_WIDTH-1:0]     green_in,
    input  wire logic [ccm_pkg::SAMPLE_WIDTH-1:0]     blue_in,

    // result channel
    output logic                                      res_valid,
    input  wire logic                                 res_stall,
    output logic [ccm_pkg::SAMPLE_WIDTH-1:0]          red_out,
    output logic [ccm_pkg::SAMPLE_WIDTH-1:0]          green_out,
    output logic [ccm_pkg::SAMPLE_WIDTH-1:0]          blue_out,

    // configuration write channel
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [ccm_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire logic [ccm_pkg::ROW_WIDTH-1:0]        cfg_data
);

    localparam int DW = ccm_pkg::SAMPLE_WIDTH;
    localparam int NW = ccm_pkg::NARROW_WIDTH;

    logic [ccm_pkg::ROW_WIDTH-1:0] row_red;
    logic [ccm_pkg::ROW_WIDTH-1:0] row_green;
    logic [ccm_pkg::ROW_WIDTH-1:0] row_blue;
    logic                          ten_bit;

    // stage valids: input samples, products, sums, output
    logic v_in_reg;
    logic v_mul_reg;
    logic v_sum_reg;
    logic v_out_reg;
    logic v_in_next;
    logic v_mul_next;
    logic v_sum_next;
    logic v_out_next;

    // a stage may load when it is empty or its contents move on
    logic          adv_in;
    ccm_pkg::adv_t adv;

    logic [DW-1:0] red_reg;
    logic [DW-1:0] green_reg;
    logic [DW-1:0] blue_reg;
    logic [DW-1:0] red_next;
    logic [DW-1:0] green_next;
    logic [DW-1:0] blue_next;

    ccm_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .row_red   (row_red),
        .row_green (row_green),
        .row_blue  (row_blue),
        .ten_bit   (ten_bit)
    );

    // backpressure chain, output first
    always_comb
    begin
        adv.clamp = !v_out_reg || !res_stall;
        adv.sum   = !v_sum_reg || adv.clamp;
        adv.mul   = !v_mul_reg || adv.sum;
        adv_in    = !v_in_reg  || adv.mul;
    end

    assign pix_stall = !adv_in;

    always_comb
    begin
        v_in_next  = adv_in    ? pix_valid : v_in_reg;
        v_mul_next = adv.mul   ? v_in_reg  : v_mul_reg;
        v_sum_next = adv.sum   ? v_mul_reg : v_sum_reg;
        v_out_next = adv.clamp ? v_sum_reg : v_out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_in_reg  <= 1'b0;
            v_mul_reg <= 1'b0;
            v_sum_reg <= 1'b0;
            v_out_reg <= 1'b0;
        end
        else
        begin
            v_in_reg  <= v_in_next;
            v_mul_reg <= v_mul_next;
            v_sum_reg <= v_sum_next;
            v_out_reg <= v_out_next;
        end
    end

    // 8-bit mode drops the upper sample bits
    always_comb
    begin
        if (ten_bit)
        begin
            red_next   = red_in;
            green_next = green_in;
            blue_next  = blue_in;
        end
        else
        begin
            red_next   = {{(DW-NW){1'b0}}, red_in[NW-1:0]};
            green_next = {{(DW-NW){1'b0}}, green_in[NW-1:0]};
            blue_next  = {{(DW-NW){1'b0}}, blue_in[NW-1:0]};
        end
    end

    // sample capture stage, payload only
    always_ff @(posedge clk)
    begin
        if (adv_in)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    // one multiply, sum and clamp pipeline per output channel
    ccm_row u_row_red
    (
        .clk       (clk),
        .adv       (adv),
        .coeff_row (row_red),
        .ten_bit   (ten_bit),
        .red       (red_reg),
        .green     (green_reg),
        .blue      (blue_reg),
        .result    (red_out)
    );

    ccm_row u_row_green
    (
        .clk       (clk),
        .adv       (adv),
        .coeff_row (row_green),
        .ten_bit   (ten_bit),
        .red       (red_reg),
        .green     (green_reg),
        .blue      (blue_reg),
        .result    (green_out)
    );

    ccm_row u_row_blue
    (
        .clk       (clk),
        .adv       (adv),
        .coeff_row (row_blue),
        .ten_bit   (ten_bit),
        .red       (red_reg),
        .green     (green_reg),
        .blue      (blue_reg),
        .result    (blue_out)
    );

    assign res_valid = v_out_reg;

endmodule

`default_nettype wire

FILE: rtl/core/ccm_cfg_regs.sv
`default_nettype none

module ccm_cfg_regs
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [ccm_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire logic [ccm_pkg::ROW_WIDTH-1:0]        cfg_data,
    output logic [ccm_pkg::ROW_WIDTH-1:0]             row_red,
    output logic [ccm_pkg::ROW_WIDTH-1:0]             row_green,
    output logic [ccm_pkg::ROW_WIDTH-1:0]             row_blue,
    output logic                                      ten_bit
);

    logic [ccm_pkg::ROW_WIDTH-1:0] row_red_reg;
    logic [ccm_pkg::ROW_WIDTH-1:0] row_green_reg;
    logic [ccm_pkg::ROW_WIDTH-1:0] row_blue_reg;
    logic                          ten_bit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_red_reg   <= ccm_pkg::ROW_RED_RESET;
            row_green_reg <= ccm_pkg::ROW_GREEN_RESET;
            row_blue_reg  <= ccm_pkg::ROW_BLUE_RESET;
            ten_bit_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ccm_pkg::CFG_ROW_RED:   row_red_reg   <= cfg_data;
                ccm_pkg::CFG_ROW_GREEN: row_green_reg <= cfg_data;
                ccm_pkg::CFG_ROW_BLUE:  row_blue_reg  <= cfg_data;
                ccm_pkg::CFG_TEN_BIT:   ten_bit_reg   <= cfg_data[0];
                default:                ten_bit_reg   <= ten_bit_reg;
            endcase
        end
    end

    assign row_red   = row_red_reg;
    assign row_green = row_green_reg;
    assign row_blue  = row_blue_reg;
    assign ten_bit   = ten_bit_reg;

endmodule

`default_nettype wire

FILE: rtl/core/ccm_row.sv
`default_nettype none

module ccm_row
(
    input  wire logic                                clk,
    input  wire ccm_pkg::adv_t                       adv,
    input  wire logic [ccm_pkg::ROW_WIDTH-1:0]       coeff_row,
    input  wire logic                                ten_bit,
    input  wire logic [ccm_pkg::SAMPLE_WIDTH-1:0]    red,
    input  wire logic [ccm_pkg::SAMPLE_WIDTH-1:0]    green,
    input  wire logic [ccm_pkg::SAMPLE_WIDTH-1:0]    blue,
    output logic [ccm_pkg::SAMPLE_WIDTH-1:0]         result
);

    localparam int CW = ccm_pkg::COEFF_WIDTH;
    localparam int PW = ccm_pkg::PROD_WIDTH;
    localparam int SW = ccm_pkg::SUM_WIDTH;
    localparam int FR = ccm_pkg::COEFF_FRAC;
    localparam int DW = ccm_pkg::SAMPLE_WIDTH;

    logic signed [CW-1:0] coeff_r;
    logic signed [CW-1:0] coeff_g;
    logic signed [CW-1:0] coeff_b;

    logic signed [PW-1:0] prod_r_reg;
    logic signed [PW-1:0] prod_g_reg;
    logic signed [PW-1:0] prod_b_reg;
    logic signed [PW-1:0] prod_r_next;
    logic signed [PW-1:0] prod_g_next;
    logic signed [PW-1:0] prod_b_next;

    logic signed [SW-1:0] sum_reg;
    logic signed [SW-1:0] sum_next;

    logic signed [SW-1:0] limit_scaled;
    logic [DW-1:0]        limit;
    logic [DW-1:0]        result_reg;
    logic [DW-1:0]        result_next;

    assign coeff_r = coeff_row[3*CW-1:2*CW];
    assign coeff_g = coeff_row[2*CW-1:CW];
    assign coeff_b = coeff_row[CW-1:0];

    // products, sample widened with a zero sign bit
    always_comb
    begin
        prod_r_next = PW'($signed({1'b0, red}))   * PW'(coeff_r);
        prod_g_next = PW'($signed({1'b0, green})) * PW'(coeff_g);
        prod_b_next = PW'($signed({1'b0, blue}))  * PW'(coeff_b);
    end

    always_comb
    begin
        sum_next = SW'(prod_r_reg) + SW'(prod_g_reg) + SW'(prod_b_reg);
    end

    // clamp to zero and the mode maximum, floor otherwise
    always_comb
    begin
        limit        = ten_bit ? ccm_pkg::MAX_10BIT : ccm_pkg::MAX_8BIT;
        limit_scaled = $signed({{(SW-DW-FR){1'b0}}, limit, {FR{1'b0}}});
        if (sum_reg < 0)
        begin
            result_next = ccm_pkg::MIN_OUT;
        end
        else if (sum_reg > limit_scaled)
        begin
            result_next = limit;
        end
        else
        begin
            result_next = sum_reg[FR+DW-1:FR];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.mul)
        begin
            prod_r_reg <= prod_r_next;
            prod_g_reg <= prod_g_next;
            prod_b_reg <= prod_b_next;
        end
        if (adv.sum)
        begin
            sum_reg <= sum_next;
        end
        if (adv.clamp)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
module tb_top;
    import ccm_pkg::*;

    // cycles with no request, result or register write before the run is abandoned
    localparam int STALL_LIMIT  = 2000;
    // quiet cycles after the last result, more than the pipeline depth
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;
    localparam int UNITY        = 1 << COEFF_FRAC;

    typedef logic [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic [COEFF_WIDTH-1:0]  coeff_t;
    typedef logic [ROW_WIDTH-1:0]    row_t;

    typedef struct packed {
        sample_t red;
        sample_t green;
        sample_t blue;
    } pixel_t;

    // coefficient extremes of q4.12
    localparam coeff_t COEFF_MAX       = 16'h7FFF;
    localparam coeff_t COEFF_MIN       = 16'h8000;
    localparam coeff_t COEFF_MINUS_ONE = -COEFF_ONE;
    // one step above unity, to land just past the clamp limit
    localparam coeff_t COEFF_ONE_PLUS  = COEFF_ONE + 16'd1;
    localparam coeff_t COEFF_TINY_NEG  = 16'hFFFF;
    localparam coeff_t COEFF_TINY      = 16'h0001;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;

    logic       pix_valid = 1'b0;
    logic       pix_stall;
    sample_t    red_in    = '0;
    sample_t    green_in  = '0;
    sample_t    blue_in   = '0;

    logic       res_valid;
    logic       res_stall = 1'b0;
    sample_t    red_out;
    sample_t    green_out;
    sample_t    blue_out;

    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    cfg_index_t cfg_index = CFG_ROW_RED;
    row_t       cfg_data  = '0;

    // matrix and mode as the block should hold them, tracked from accepted writes
    row_t       cur_red_row   = ROW_RED_RESET;
    row_t       cur_green_row = ROW_GREEN_RESET;
    row_t       cur_blue_row  = ROW_BLUE_RESET;
    logic       cur_ten_bit   = 1'b0;

    // corrected pixels owed by the block, oldest first
    pixel_t      pending_pixels[$];
    int unsigned error_count   = 0;
    int unsigned idle_cycles   = 0;
    int unsigned send_idle_pct = 17;
    int unsigned recv_idle_pct = 50;

    color_correction_matrix i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------- prediction

    // one output channel: exact dot product, clamp to [0, mode maximum], then floor
    function automatic sample_t row_result(row_t row, pixel_t px);
        logic signed [SUM_WIDTH-1:0] acc;
        logic signed [SUM_WIDTH-1:0] ceiling;
        sample_t keep;
        sample_t top;
        // narrow mode drops the upper sample bits
        keep = cur_ten_bit ? '1 : sample_t'({NARROW_WIDTH{1'b1}});
        top  = cur_ten_bit ? MAX_10BIT : MAX_8BIT;
        acc = $signed({1'b0, px.red & keep})   * $signed(row[2*COEFF_WIDTH +: COEFF_WIDTH])
            + $signed({1'b0, px.green & keep}) * $signed(row[COEFF_WIDTH +: COEFF_WIDTH])
            + $signed({1'b0, px.blue & keep})  * $signed(row[0 +: COEFF_WIDTH]);
        ceiling = top;
        ceiling = ceiling <<< COEFF_FRAC;
        if (acc < 0)
            return MIN_OUT;
        if (acc > ceiling)
            return top;
        return acc[COEFF_FRAC +: SAMPLE_WIDTH];
    endfunction

    function automatic pixel_t correct_pixel(pixel_t px);
        pixel_t res;
        res.red   = row_result(cur_red_row, px);
        res.green = row_result(cur_green_row, px);
        res.blue  = row_result(cur_blue_row, px);
        return res;
    endfunction

    function automatic void note_error(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
    endfunction

    // ---------------------------------------------------------------- checking

    // all three channels sampled at the edge, so values are those before the edge
    always @(posedge clk)
    begin
        pixel_t got;
        pixel_t want;
        logic   moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                moved = 1'b1;
                case (cfg_index)
                    CFG_ROW_RED:   cur_red_row   = cfg_data;
                    CFG_ROW_GREEN: cur_green_row = cfg_data;
                    CFG_ROW_BLUE:  cur_blue_row  = cfg_data;
                    CFG_TEN_BIT:   cur_ten_bit   = cfg_data[0];
                    default:       ;
                endcase
            end
            if (pix_valid && !pix_stall)
            begin
                moved = 1'b1;
                pending_pixels.push_back(correct_pixel('{red_in, green_in, blue_in}));
            end
            if (res_valid && !res_stall)
            begin
                moved = 1'b1;
                got = '{red_out, green_out, blue_out};
                if (pending_pixels.size() == 0)
                    note_error($sformatf("result with no request outstanding: %0d %0d %0d",
                                         got.red, got.green, got.blue));
                else
                begin
                    want = pending_pixels.pop_front();
                    if (got.red !== want.red)
                        note_error($sformatf("red_out expected %0d, got %0d",
                                             want.red, got.red));
                    if (got.green !== want.green)
                        note_error($sformatf("green_out expected %0d, got %0d",
                                             want.green, got.green));
                    if (got.blue !== want.blue)
                        note_error($sformatf("blue_out expected %0d, got %0d",
                                             want.blue, got.blue));
                end
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge clk)
        res_stall <= ($urandom_range(99) < recv_idle_pct);

    // watchdog on a hung handshake
    initial
    begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // ---------------------------------------------------------------- driving

    // one pixel request, with a random gap in front; returns at the accepting edge
    task automatic send_pixel(input pixel_t px);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0)
        begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_valid <= 1'b1;
        red_in    <= px.red;
        green_in  <= px.green;
        blue_in   <= px.blue;
        do
            @(posedge clk);
        while (pix_stall !== 1'b0);
    endtask

    // sender holds off until every outstanding result has come back
    task automatic wait_drained();
        pix_valid <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    // leaves cfg_valid high so back-to-back writes need no second assignment
    task automatic write_register(input cfg_index_t idx, input row_t value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
    endtask

    // every register written, only with the pipeline empty
    task automatic set_matrix(input row_t red_row, input row_t green_row,
                              input row_t blue_row, input logic ten_bit);
        row_t mode_word;
        wait_drained();
        // upper bits of the mode word are junk that the block must ignore
        mode_word    = row_t'({$urandom, $urandom});
        mode_word[0] = ten_bit;
        write_register(CFG_ROW_RED, red_row);
        write_register(CFG_ROW_GREEN, green_row);
        write_register(CFG_ROW_BLUE, blue_row);
        write_register(CFG_TEN_BIT, mode_word);
        cfg_valid <= 1'b0;
    endtask

    function automatic coeff_t random_coeff();
        case ($urandom_range(3))
            0:       return coeff_t'($urandom);
            1, 2:    return coeff_t'(int'($urandom_range(2 * UNITY)) - UNITY);
            default:
                case ($urandom_range(3))
                    0:       return COEFF_MAX;
                    1:       return COEFF_MIN;
                    2:       return '0;
                    default: return COEFF_ONE;
                endcase
        endcase
    endfunction

    function automatic row_t random_row();
        return {random_coeff(), random_coeff(), random_coeff()};
    endfunction

    function automatic pixel_t random_pixel();
        return '{sample_t'($urandom), sample_t'($urandom), sample_t'($urandom)};
    endfunction

    // ---------------------------------------------------------------- tests

    // identity matrix and 8-bit mode straight out of reset
    task automatic test_identity_reset();
        send_pixel('{10'd0, 10'd0, 10'd0});
        send_pixel('{10'h3FF, 10'h3FF, 10'h3FF});
        // upper sample bits must vanish in narrow mode
        send_pixel('{10'h100, 10'h1FF, 10'h2AA});
    endtask

    // 8-bit clamp edges: negative, exactly at max, over max, just past max
    task automatic test_clamp_edges();
        set_matrix({COEFF_ONE, COEFF_ONE, 16'h0000},
                   {COEFF_MINUS_ONE, COEFF_ONE, 16'h0000},
                   {COEFF_ONE_PLUS, 16'h0000, 16'h0000},
                   1'b0);
        send_pixel('{10'd255, 10'd0, 10'd0});
        send_pixel('{10'd200, 10'd100, 10'd50});
        send_pixel('{10'd0, 10'd255, 10'd7});
        send_pixel('{10'h3FF, 10'h300, 10'h1FF});
        send_pixel('{10'd1, 10'd1, 10'd1});
    endtask

    // 10-bit mode with the coefficient extremes
    task automatic test_ten_bit_extremes();
        set_matrix({COEFF_MAX, COEFF_MAX, COEFF_MAX},
                   {COEFF_MIN, COEFF_MIN, COEFF_MIN},
                   {COEFF_ONE_PLUS, COEFF_TINY_NEG, COEFF_TINY},
                   1'b1);
        send_pixel('{10'd0, 10'd0, 10'd0});
        send_pixel('{10'd1023, 10'd1023, 10'd1023});
        send_pixel('{10'd1023, 10'd0, 10'd0});
        send_pixel('{10'd1, 10'd0, 10'd0});
        send_pixel('{10'd512, 10'd511, 10'd3});
        send_pixel('{10'd1023, 10'd0, 10'd1023});
        send_pixel('{10'd0, 10'd1023, 10'd0});
    endtask

    // random pixels under one idling profile, one matrix per sample mode
    task automatic test_random_stream(input int unsigned send_pct, input int unsigned recv_pct,
                                      input int unsigned count);
        int unsigned pause_at;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int seg = 0; seg < 2; seg++)
        begin
            set_matrix(random_row(), random_row(), random_row(), seg == 1);
            pause_at = $urandom_range(count / 2 - 1);
            for (int unsigned i = 0; i < count / 2; i++)
            begin
                send_pixel(random_pixel());
                // let the pipeline run dry once per segment
                if (i == pause_at)
                    wait_drained();
            end
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_identity_reset();
        test_clamp_edges();
        test_ten_bit_extremes();

        test_random_stream(17, 50, 500);
        test_random_stream(50, 17, 500);
        test_random_stream(0, 0, 500);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
